// ===== sv/cbis_pkg.sv =====
// shared types, codes and defaults of the branch and interrupt sequencer
package cbis_pkg;

    localparam int IRQ_LINES_DEFAULT = 5;

    // beat kinds
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_IRQ   = 2'd1;
    localparam logic [1:0] KIND_WR_IE = 2'd2;
    localparam logic [1:0] KIND_WR_IF = 2'd3;

    // decoded instruction classes
    localparam logic [3:0] CLS_SEQ    = 4'd0;
    localparam logic [3:0] CLS_JP     = 4'd1;
    localparam logic [3:0] CLS_JPCC   = 4'd2;
    localparam logic [3:0] CLS_JPHL   = 4'd3;
    localparam logic [3:0] CLS_JR     = 4'd4;
    localparam logic [3:0] CLS_JRCC   = 4'd5;
    localparam logic [3:0] CLS_CALL   = 4'd6;
    localparam logic [3:0] CLS_CALLCC = 4'd7;
    localparam logic [3:0] CLS_RET    = 4'd8;
    localparam logic [3:0] CLS_RETCC  = 4'd9;
    localparam logic [3:0] CLS_RETI   = 4'd10;
    localparam logic [3:0] CLS_RST    = 4'd11;
    localparam logic [3:0] CLS_EIDI   = 4'd12;
    localparam logic [3:0] CLS_HALT   = 4'd13;

    // branch conditions from opcode bits 4:3
    localparam logic [1:0] COND_NZ = 2'd0;
    localparam logic [1:0] COND_Z  = 2'd1;
    localparam logic [1:0] COND_NC = 2'd2;
    localparam logic [1:0] COND_C  = 2'd3;

    // idle ticks after an interrupt dispatch
    localparam logic [7:0] IRQ_IDLE = 8'd4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  reg_or_irq;
        logic [3:0]  instr_class;
        logic [7:0]  opcode_byte;
        logic [1:0]  instr_length;
        logic [3:0]  base_cycles;
        logic [3:0]  taken_cycles;
        logic [15:0] operand_word;
        logic [15:0] hl_pair;
        logic [15:0] stack_top;
        logic        zero_flag;
        logic        carry_flag;
    } item_t;

    typedef struct packed {
        logic [15:0] pc;
        logic        ime;
        logic        halt;
        logic [7:0]  idle;
        logic [7:0]  ie;
        logic [7:0]  iflag;
    } seq_state_t;

    typedef struct packed {
        logic [15:0] prog_counter;
        logic        push_req;
        logic [15:0] push_word;
        logic        pop_req;
        logic        executed;
        logic        irq_served;
        logic        halted;
        logic        bad_instr;
        logic [7:0]  flags_pending;
        logic        master_enable;
    } result_t;

endpackage

// ===== sv/cbis_exec.sv =====
// single-pass next-state and result logic for one beat
module cbis_exec #(
    parameter int IRQ_LINES = cbis_pkg::IRQ_LINES_DEFAULT
) (
    input  cbis_pkg::item_t      item,
    input  cbis_pkg::seq_state_t cur,
    output cbis_pkg::seq_state_t nxt,
    output cbis_pkg::result_t    res
);

    localparam logic [7:0] LINE_MASK = 8'((9'd1 << IRQ_LINES) - 9'd1);
    localparam logic [7:0] LINE_CNT  = 8'(IRQ_LINES);

    logic [7:0]  pend;
    logic [2:0]  irq_idx;
    logic [15:0] seq_pc;
    logic [15:0] rel_pc;
    logic        cond_ok;
    logic [4:0]  cost;
    logic        push;
    logic [15:0] pword;
    logic        pop;
    logic        exec;
    logic        served;
    logic        bad;

    assign pend   = cur.ie & cur.iflag & LINE_MASK;
    assign seq_pc = cur.pc + {14'd0, item.instr_length};
    assign rel_pc = seq_pc + {{8{item.operand_word[7]}}, item.operand_word[7:0]};

    // lowest pending line wins
    always_comb
    begin
        irq_idx = 3'd0;
        for (int k = 7; k >= 0; k--)
        begin
            if (pend[k])
            begin
                irq_idx = 3'(k);
            end
        end
    end

    always_comb
    begin
        case (item.opcode_byte[4:3])
            cbis_pkg::COND_NZ: cond_ok = !item.zero_flag;
            cbis_pkg::COND_Z:  cond_ok = item.zero_flag;
            cbis_pkg::COND_NC: cond_ok = !item.carry_flag;
            default:           cond_ok = item.carry_flag;
        endcase
    end

    always_comb
    begin
        nxt    = cur;
        push   = 1'b0;
        pword  = 16'd0;
        pop    = 1'b0;
        exec   = 1'b0;
        served = 1'b0;
        bad    = 1'b0;
        cost   = {1'b0, item.base_cycles};
        case (item.kind)
            cbis_pkg::KIND_IRQ:
            begin
                if (item.reg_or_irq < LINE_CNT)
                begin
                    nxt.iflag = cur.iflag | (8'd1 << item.reg_or_irq[2:0]);
                end
            end
            cbis_pkg::KIND_WR_IE: nxt.ie    = item.reg_or_irq;
            cbis_pkg::KIND_WR_IF: nxt.iflag = item.reg_or_irq;
            default:
            begin
                if (cur.idle != 8'd0)
                begin
                    nxt.idle = cur.idle - 8'd1;
                end
                else
                begin
                    if (pend != 8'd0)
                    begin
                        nxt.halt = 1'b0;
                    end
                    if (!nxt.halt)
                    begin
                        if (cur.ime && pend != 8'd0)
                        begin
                            nxt.ime           = 1'b0;
                            nxt.iflag         = cur.iflag & ~(8'd1 << irq_idx);
                            push              = 1'b1;
                            pword             = cur.pc;
                            nxt.pc            = {10'd1, irq_idx, 3'd0};
                            served            = 1'b1;
                            nxt.idle          = cbis_pkg::IRQ_IDLE;
                        end
                        else
                        begin
                            exec = 1'b1;
                            case (item.instr_class)
                                cbis_pkg::CLS_SEQ:  nxt.pc = seq_pc;
                                cbis_pkg::CLS_JP:   nxt.pc = item.operand_word;
                                cbis_pkg::CLS_JPCC:
                                begin
                                    nxt.pc = cond_ok ? item.operand_word : seq_pc;
                                    if (cond_ok)
                                    begin
                                        cost = cost + {1'b0, item.taken_cycles};
                                    end
                                end
                                cbis_pkg::CLS_JPHL: nxt.pc = item.hl_pair;
                                cbis_pkg::CLS_JR:   nxt.pc = rel_pc;
                                cbis_pkg::CLS_JRCC:
                                begin
                                    nxt.pc = cond_ok ? rel_pc : seq_pc;
                                    if (cond_ok)
                                    begin
                                        cost = cost + {1'b0, item.taken_cycles};
                                    end
                                end
                                cbis_pkg::CLS_CALL:
                                begin
                                    push   = 1'b1;
                                    pword  = seq_pc;
                                    nxt.pc = item.operand_word;
                                end
                                cbis_pkg::CLS_CALLCC:
                                begin
                                    if (cond_ok)
                                    begin
                                        push   = 1'b1;
                                        pword  = seq_pc;
                                        nxt.pc = item.operand_word;
                                        cost   = cost + {1'b0, item.taken_cycles};
                                    end
                                    else
                                    begin
                                        nxt.pc = seq_pc;
                                    end
                                end
                                cbis_pkg::CLS_RET:
                                begin
                                    pop    = 1'b1;
                                    nxt.pc = item.stack_top;
                                end
                                cbis_pkg::CLS_RETCC:
                                begin
                                    if (cond_ok)
                                    begin
                                        pop    = 1'b1;
                                        nxt.pc = item.stack_top;
                                        cost   = cost + {1'b0, item.taken_cycles};
                                    end
                                    else
                                    begin
                                        nxt.pc = seq_pc;
                                    end
                                end
                                cbis_pkg::CLS_RETI:
                                begin
                                    nxt.ime = 1'b1;
                                    pop     = 1'b1;
                                    nxt.pc  = item.stack_top;
                                end
                                cbis_pkg::CLS_RST:
                                begin
                                    push   = 1'b1;
                                    pword  = seq_pc;
                                    nxt.pc = {10'd0, item.opcode_byte[5:3], 3'd0};
                                end
                                cbis_pkg::CLS_EIDI:
                                begin
                                    nxt.ime = item.opcode_byte[3];
                                    nxt.pc  = seq_pc;
                                end
                                cbis_pkg::CLS_HALT:
                                begin
                                    nxt.halt = 1'b1;
                                    nxt.pc   = seq_pc;
                                end
                                default:
                                begin
                                    exec = 1'b0;
                                    bad  = 1'b1;
                                end
                            endcase
                            if (exec)
                            begin
                                nxt.idle = (cost != 5'd0) ? {3'd0, cost - 5'd1} : 8'd0;
                            end
                        end
                    end
                end
            end
        endcase
    end

    assign res.prog_counter  = nxt.pc;
    assign res.push_req      = push;
    assign res.push_word     = pword;
    assign res.pop_req       = pop;
    assign res.executed      = exec;
    assign res.irq_served    = served;
    assign res.halted        = nxt.halt;
    assign res.bad_instr     = bad;
    assign res.flags_pending = nxt.iflag;
    assign res.master_enable = nxt.ime;

endmodule

// ===== sv/cpu_branch_interrupt_sequencer.sv =====
// top level of the program counter, halt and interrupt dispatch sequencer
//
//  channel   handshake              payload
//  -------   ---------------------  ----------------------------------------------
//  input     in_valid / in_ready    kind, reg_or_irq, instr_class, opcode_byte,
//                                   instr_length, base_cycles, taken_cycles,
//                                   operand_word, hl_pair, stack_top,
//                                   zero_flag, carry_flag
//  output    out_valid / out_ready  prog_counter, push_req, push_word, pop_req,
//                                   executed, irq_served, halted, bad_instr,
//                                   flags_pending, master_enable
//
// one beat per cycle sustained while out_ready is high; a beat is captured in the
// input register, and its result is written to the output register as it moves on
// the sequencer state updates as a beat moves from input to output register,
// so the next beat already sees it with no bubble
// reset clears pc, ime, halt, idle countdown, ie and if, and both valid flags
// when out_ready is low the output holds, the input register holds its beat,
// and in_ready drops only once both registers are full
module cpu_branch_interrupt_sequencer #(
    parameter int IRQ_LINES = cbis_pkg::IRQ_LINES_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [7:0]  reg_or_irq,
    input  logic [3:0]  instr_class,
    input  logic [7:0]  opcode_byte,
    input  logic [1:0]  instr_length,
    input  logic [3:0]  base_cycles,
    input  logic [3:0]  taken_cycles,
    input  logic [15:0] operand_word,
    input  logic [15:0] hl_pair,
    input  logic [15:0] stack_top,
    input  logic        zero_flag,
    input  logic        carry_flag,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] prog_counter,
    output logic        push_req,
    output logic [15:0] push_word,
    output logic        pop_req,
    output logic        executed,
    output logic        irq_served,
    output logic        halted,
    output logic        bad_instr,
    output logic [7:0]  flags_pending,
    output logic        master_enable
);

    // input stage
    cbis_pkg::item_t      item_reg;
    cbis_pkg::item_t      item_next;
    logic                 in_valid_reg;

    // architectural state
    cbis_pkg::seq_state_t state_reg;
    cbis_pkg::seq_state_t state_next;

    // output stage
    cbis_pkg::result_t    res_reg;
    cbis_pkg::result_t    res_next;
    logic                 out_valid_reg;

    logic                 advance;
    logic                 in_take;

    // beat moves on when the output register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    assign item_next.kind         = kind;
    assign item_next.reg_or_irq   = reg_or_irq;
    assign item_next.instr_class  = instr_class;
    assign item_next.opcode_byte  = opcode_byte;
    assign item_next.instr_length = instr_length;
    assign item_next.base_cycles  = base_cycles;
    assign item_next.taken_cycles = taken_cycles;
    assign item_next.operand_word = operand_word;
    assign item_next.hl_pair      = hl_pair;
    assign item_next.stack_top    = stack_top;
    assign item_next.zero_flag    = zero_flag;
    assign item_next.carry_flag   = carry_flag;

    // all of a beat's work: one short cone from input register and state
    cbis_exec #(
        .IRQ_LINES (IRQ_LINES)
    ) u_exec (
        .item (item_reg),
        .cur  (state_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    // control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg <= item_next;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign prog_counter  = res_reg.prog_counter;
    assign push_req      = res_reg.push_req;
    assign push_word     = res_reg.push_word;
    assign pop_req       = res_reg.pop_req;
    assign executed      = res_reg.executed;
    assign irq_served    = res_reg.irq_served;
    assign halted        = res_reg.halted;
    assign bad_instr     = res_reg.bad_instr;
    assign flags_pending = res_reg.flags_pending;
    assign master_enable = res_reg.master_enable;

    // a dispatch pushes, clears ime and lands on a vector slot
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && irq_served) |->
            (push_req && !master_enable && !executed && prog_counter[15:6] == 10'd1
             && prog_counter[2:0] == 3'd0))
        else $error("interrupt dispatch result malformed");

    // an unknown class never counts as executed and never touches the stack
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bad_instr) |-> (!executed && !push_req && !pop_req && !irq_served))
        else $error("unknown class result malformed");

    // a beat still in the input register is never dropped while output stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !out_ready) |=> (in_valid_reg && out_valid_reg))
        else $error("beat lost during output stall");

    // state only changes when a beat moves to the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("sequencer state changed without a beat");

endmodule
